>>> src/pcfc_pkg.sv
// Shared types and fixed constants for the pixel charge front end channel.
// Used by the top level and the bench through scoped names; no dependencies.
`default_nettype none

package pcfc_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_GLOBAL_THRESHOLD = 2'd0,
		CFG_BASELINE_VOLTAGE = 2'd1,
		CFG_CHARGE_GAIN      = 2'd2
	} cfg_reg_t;

	localparam int V_W        = 24;
	localparam int GTHR_W     = 8;
	localparam int BASE_W     = 17;
	localparam int GAIN_W     = 16;
	localparam int CFG_DATA_W = 17;
	localparam int THR_W      = 20;

	// voltages in signed Q.16 volts
	localparam logic signed [V_W-1:0] V_MAX        = 24'sh7FFFFF;
	localparam logic signed [V_W-1:0] V_MIN        = -24'sh800000;
	localparam logic signed [V_W-1:0] INIT_VOLTAGE = 24'sd32768;

	// threshold at five times the voltage scale
	localparam logic [THR_W-1:0] THR_BASE_X5    = 20'd154010;
	localparam logic [THR_W-1:0] GLOBAL_STEP_X5 = 20'd2304;

	// first voltage at or above 1.8 V full scale (589824/5 rounded up)
	localparam logic signed [V_W-1:0] FULL_SCALE_V = 24'sd117965;
	localparam logic [19:0] FULL_SCALE_X5 = 20'd589824;

	// divide by 1179648 = 9 * 2^17: shift, then reciprocal of nine
	localparam int QUANT_SHIFT   = 17;
	localparam int DIV9_SHIFT    = 24;
	localparam int DIV9_RECIP_W  = 21;
	localparam logic [DIV9_RECIP_W-1:0] DIV9_RECIP = 21'd1864135;

endpackage

`default_nettype wire

>>> src/pcfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/pixel_charge_frontend_channel_top.sv
// Pixel charge front end: one tick of one channel per beat, per-channel state
// in a RAM. Depends on pcfc_pkg and pcfc_ram.
//
// Each input beat carries a channel index, its charge, sample level, reset
// flags and trim, and produces exactly one result beat with the channel's held
// ADC code, a hit flag and done_res. The block works on one beat at a time: the
// next beat is accepted only once the read-modify-write of the channel entry
// (RAM read, charge multiply, subtract with saturation, quantizer multiply,
// reciprocal divide by nine, then write-back) is through. A finished result
// sits in an output register; the next beat is accepted while it waits, and
// the block holds its last step only if the previous result is still not
// taken. Channel state after reset reads as 0.5 V, code zero, sample low,
// tracked by one valid bit per channel; no clearing pass is needed.
// Configuration writes take effect at once and belong in idle periods.
`default_nettype none

module pixel_charge_frontend_channel_top #(
	parameter int CHANNELS  = 64,
	parameter int ADC_BITS  = 8,
	parameter int TRIM_BITS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [16:0]         cfg_wdata,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [5:0]          channel,
	input  wire logic signed [15:0]  charge,
	input  wire logic                sample_level,
	input  wire logic                channel_reset,
	input  wire logic                chip_reset,
	input  wire logic [4:0]          chan_trim,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [5:0]               out_channel,
	output logic [7:0]               held_adc,
	output logic                     hit,
	output logic                     done_res
);

	localparam int CH_W  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int V_W   = pcfc_pkg::V_W;
	localparam int RAM_W = V_W + ADC_BITS + 1;
	localparam logic [ADC_BITS-1:0] CODE_TOP = {ADC_BITS{1'b1}};
	localparam int QK    = 10 * ((1 << ADC_BITS) - 1);
	localparam int QK_W  = $clog2(QK + 1);
	localparam int NP_W  = 17 + QK_W;
	localparam int N_W   = NP_W + 1;
	localparam int M_W   = N_W - pcfc_pkg::QUANT_SHIFT;
	localparam int QP_W  = M_W + pcfc_pkg::DIV9_RECIP_W;
	localparam int Q0_W  = QP_W - pcfc_pkg::DIV9_SHIFT;
	localparam logic [4:0] TRIM_MASK = 5'((1 << TRIM_BITS) - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SUB,
		S_QMUL,
		S_QDIV,
		S_DONE
	} state_t;

	// ------------------------------------------------------------------
	// configuration registers
	logic [pcfc_pkg::GTHR_W-1:0] gthr_q;
	logic [pcfc_pkg::BASE_W-1:0] baseline_q;
	logic [pcfc_pkg::GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gthr_q     <= '0;
			baseline_q <= 17'd32768;
			gain_q     <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				pcfc_pkg::CFG_GLOBAL_THRESHOLD: gthr_q     <= cfg_wdata[7:0];
				pcfc_pkg::CFG_BASELINE_VOLTAGE: baseline_q <= cfg_wdata;
				pcfc_pkg::CFG_CHARGE_GAIN:      gain_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// channel index wrap table
	logic [CH_W-1:0] wrap_tab [64];
	for (genvar gi = 0; gi < 64; gi++) begin : g_wrap
		assign wrap_tab[gi] = CH_W'(gi % CHANNELS);
	end

	// ------------------------------------------------------------------
	// control
	state_t              state_q;
	logic [CHANNELS-1:0] vld_q;
	logic                out_valid_q;
	logic                in_acc;
	logic                out_free;
	logic [CH_W-1:0]     in_ch;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ch    = wrap_tab[channel];

	// datapath registers
	logic [CH_W-1:0]                 ch_q;
	logic signed [15:0]              charge_q;
	logic                            sample_q;
	logic                            rst_q;
	logic [4:0]                      trim_q;
	logic                            ent_vld_q;
	logic signed [V_W-1:0]           v0_q;
	logic [ADC_BITS-1:0]             code_q;
	logic                            last_q;
	logic signed [32:0]              prod_q;
	logic signed [V_W-1:0]           v_q;
	logic                            hit_q;
	logic [NP_W-1:0]                 np_q;
	logic [M_W-1:0]                  m_q;
	logic [QP_W-1:0]                 qp_q;

	// RAM
	logic              ram_we;
	logic [RAM_W-1:0]  ram_wdata;
	logic [RAM_W-1:0]  ram_rdata;

	pcfc_ram #(
		.WIDTH (RAM_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_q),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (in_ch),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// combinational datapath
	localparam int THR_W_FIX = pcfc_pkg::THR_W;

	logic signed [V_W-1:0]       rd_v;
	logic [ADC_BITS-1:0]         rd_code;
	logic                        rd_last;
	logic signed [33:0]          diff;
	logic signed [V_W-1:0]       v_sat;
	logic [THR_W_FIX-1:0]        thr5;
	logic signed [27:0]          v5;
	logic [N_W-1:0]              n_sum;
	logic [M_W-1:0]              m_next;
	logic [Q0_W-1:0]             q0;
	logic [M_W-1:0]              rem;
	logic [M_W-1:0]              rem_fix;
	logic [ADC_BITS-1:0]         q_fix;
	logic [ADC_BITS-1:0]         quant;
	logic [ADC_BITS-1:0]         code_new;

	assign rd_v    = ram_rdata[RAM_W-1 -: V_W];
	assign rd_code = ram_rdata[ADC_BITS:1];
	assign rd_last = ram_rdata[0];

	always_comb begin
		diff = {{10{v0_q[V_W-1]}}, v0_q} - {prod_q[32], prod_q};
		if (diff > 34'(pcfc_pkg::V_MAX)) begin
			v_sat = pcfc_pkg::V_MAX;
		end else if (diff < 34'(pcfc_pkg::V_MIN)) begin
			v_sat = pcfc_pkg::V_MIN;
		end else begin
			v_sat = diff[V_W-1:0];
		end
	end

	assign thr5 = pcfc_pkg::THR_BASE_X5
		+ THR_W_FIX'(gthr_q) * pcfc_pkg::GLOBAL_STEP_X5
		+ {6'd0, trim_q, 9'd0};
	assign v5 = ({{4{v_q[V_W-1]}}, v_q} <<< 2) + {{4{v_q[V_W-1]}}, v_q};

	// rounded quantizer: (v*10*top + 589824) / (9 * 2^17)
	assign n_sum  = N_W'(np_q) + N_W'(pcfc_pkg::FULL_SCALE_X5);
	assign m_next = n_sum[N_W-1:pcfc_pkg::QUANT_SHIFT];
	assign q0     = qp_q[QP_W-1:pcfc_pkg::DIV9_SHIFT];
	assign rem    = m_q - M_W'(q0) * M_W'(9);

	always_comb begin
		if (rem >= M_W'(9)) begin
			q_fix   = ADC_BITS'(q0) + ADC_BITS'(1);
			rem_fix = rem - M_W'(9);
		end else begin
			q_fix   = ADC_BITS'(q0);
			rem_fix = rem;
		end
		if (v_q <= 0) begin
			quant = '0;
		end else if (v_q >= pcfc_pkg::FULL_SCALE_V) begin
			quant = CODE_TOP;
		end else begin
			quant = q_fix;
		end
		// falling sample edge latches a new code
		code_new = (last_q && !sample_q) ? quant : code_q;
	end

	assign ram_we    = (state_q == S_DONE);
	assign ram_wdata = {v_q, code_new, sample_q};

	// ------------------------------------------------------------------
	// datapath stages
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					ch_q      <= in_ch;
					charge_q  <= charge;
					sample_q  <= sample_level;
					rst_q     <= channel_reset || chip_reset;
					trim_q    <= chan_trim & TRIM_MASK;
					ent_vld_q <= vld_q[in_ch];
				end
			end
			S_READ: begin
				if (rst_q) begin
					v0_q   <= V_W'({7'd0, baseline_q});
					code_q <= '0;
				end else if (ent_vld_q) begin
					v0_q   <= rd_v;
					code_q <= rd_code;
				end else begin
					v0_q   <= pcfc_pkg::INIT_VOLTAGE;
					code_q <= '0;
				end
				last_q <= ent_vld_q && rd_last;
				prod_q <= charge_q * $signed({1'b0, gain_q});
			end
			S_SUB: begin
				v_q <= v_sat;
			end
			S_QMUL: begin
				hit_q <= v5 > $signed({8'd0, thr5});
				np_q  <= NP_W'(v_q[16:0]) * NP_W'(QK);
			end
			S_QDIV: begin
				m_q  <= m_next;
				qp_q <= QP_W'(m_next) * QP_W'(pcfc_pkg::DIV9_RECIP);
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			out_channel <= '0;
			held_adc    <= '0;
			hit         <= 1'b0;
			done_res    <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_SUB;
				S_SUB:  state_q <= S_QMUL;
				S_QMUL: state_q <= S_QDIV;
				S_QDIV: state_q <= S_DONE;
				S_DONE: begin
					vld_q[ch_q] <= 1'b1;
					// hold here until the result register frees up
					if (out_free) begin
						out_channel <= 6'(ch_q);
						held_adc    <= 8'(code_new);
						hit         <= hit_q;
						done_res    <= !sample_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// assertions
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_READ)
		else $error("accepted beat did not start a RAM read");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> vld_q[$past(ch_q)])
		else $error("written channel entry not marked valid");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the write-back step");

	a_div9_exact: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> rem_fix < M_W'(9))
		else $error("reciprocal divide by nine off by more than one");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking bench for pixel_charge_frontend_channel_top: per-channel integrator,
// threshold hit and held ADC code predicted tick by tick and compared beat by beat.
// Depends on pcfc_pkg and the top level; a driver and a monitor share the result queue.

module tb;

	localparam int CH_N        = 64;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_CAP   = 50;

	// threshold and quantizer scale at five times the voltage unit; code and voltage limits
	localparam longint THR0_X5   = 154010;
	localparam longint GSTEP_X5  = 2304;
	localparam longint TSTEP_X5  = 512;
	localparam longint FS_X5     = 589824;
	localparam longint ADC_TOP   = 255;
	localparam longint VOLT_HI   = 8388607;
	localparam longint VOLT_LO   = -8388608;

	typedef struct {
		logic [5:0]         channel;
		logic signed [15:0] charge;
		logic               sample;
		logic               ch_rst;
		logic               chip_rst;
		logic [4:0]         trim;
		int unsigned        gap;
	} tick_t;

	typedef struct {
		logic [5:0] channel;
		logic [7:0] code;
		logic       hit;
		logic       done;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [16:0] cfg_wdata = 17'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [5:0] channel = 6'd0;
	logic signed [15:0] charge = 16'sd0;
	logic sample_level = 1'b0;
	logic channel_reset = 1'b0;
	logic chip_reset = 1'b0;
	logic [4:0] chan_trim = 5'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] out_channel;
	logic [7:0] held_adc;
	logic hit;
	logic done_res;

	pixel_charge_frontend_channel_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.charge       (charge),
		.sample_level (sample_level),
		.channel_reset(channel_reset),
		.chip_reset   (chip_reset),
		.chan_trim    (chan_trim),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_channel  (out_channel),
		.held_adc     (held_adc),
		.hit          (hit),
		.done_res     (done_res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted channel state and register copies
	logic signed [23:0] volt_mem [CH_N];
	logic [7:0]         code_mem [CH_N];
	logic               samp_mem [CH_N];
	logic [7:0]         gthr_set = 8'd0;
	logic [16:0]        base_set = 17'd32768;
	logic [15:0]        gain_set = 16'd1;

	tick_t       tick_q [$];
	pix_result_t result_q [$];
	int          mismatches = 0;
	int          hold_seq = 0;

	// stimulus-side view of each channel's sample level, for edge shaping
	logic gen_samp [CH_N];

	initial begin
		for (int i = 0; i < CH_N; i++) begin
			volt_mem[i] = 24'sd32768;
			code_mem[i] = 8'd0;
			samp_mem[i] = 1'b0;
			gen_samp[i] = 1'b0;
		end
	end

	function automatic logic [7:0] adc_of(input longint v);
		longint v5;
		if (v <= 0)
			return 8'd0;
		v5 = v * 5;
		if (v5 >= FS_X5)
			return ADC_TOP[7:0];
		return 8'((v5 * ADC_TOP * 2 + FS_X5) / (FS_X5 * 2));
	endfunction

	// one read-modify-write of the channel entry; queue the result it yields
	task automatic tick_channel(input tick_t t);
		int          ch;
		longint      v;
		longint      thr5;
		pix_result_t r;
		ch = int'(t.channel);
		if (t.ch_rst || t.chip_rst) begin
			volt_mem[ch] = {7'd0, base_set};
			code_mem[ch] = 8'd0;
		end
		v = longint'(volt_mem[ch]) - longint'(t.charge) * longint'({1'b0, gain_set});
		if (v > VOLT_HI)
			v = VOLT_HI;
		if (v < VOLT_LO)
			v = VOLT_LO;
		volt_mem[ch] = v[23:0];
		thr5 = THR0_X5 + longint'(gthr_set) * GSTEP_X5 + longint'(t.trim) * TSTEP_X5;
		if (samp_mem[ch] && !t.sample)
			code_mem[ch] = adc_of(v);
		samp_mem[ch] = t.sample;
		r.channel = t.channel;
		r.code = code_mem[ch];
		r.hit = (v * 5 > thr5);
		r.done = !t.sample;
		result_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// driver: stage the next tick, wait out its gap, hold the beat until taken
	tick_t cur_tick;
	tick_t next_tick;
	logic  staged = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			staged = 1'b0;
		end else begin
			if (in_valid && in_ready)
				tick_channel(cur_tick);
			if (!in_valid || in_ready) begin
				if (!staged && tick_q.size() != 0) begin
					next_tick = tick_q.pop_front();
					staged = 1'b1;
				end
				if (staged && next_tick.gap != 0) begin
					next_tick.gap--;
					in_valid <= 1'b0;
				end else if (staged) begin
					cur_tick = next_tick;
					staged = 1'b0;
					in_valid <= 1'b1;
					channel <= next_tick.channel;
					charge <= next_tick.charge;
					sample_level <= next_tick.sample;
					channel_reset <= next_tick.ch_rst;
					chip_reset <= next_tick.chip_rst;
					chan_trim <= next_tick.trim;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat, then stall at random or on a hold-off request
	int          rx_wait = 0;
	int          hold_left = 0;
	int          hold_seen = 0;
	int          rx_count = 0;
	logic        rx_calm = 1'b0;
	pix_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("result beat with nothing expected, channel",
						int'(out_channel), -1);
				end else begin
					want = result_q.pop_front();
					if (out_channel !== want.channel)
						report_mismatch("out_channel", int'(out_channel), int'(want.channel));
					if (held_adc !== want.code)
						report_mismatch("held_adc", int'(held_adc), int'(want.code));
					if (hit !== want.hit)
						report_mismatch("hit", int'(hit), int'(want.hit));
					if (done_res !== want.done)
						report_mismatch("done_res", int'(done_res), int'(want.done));
				end
				rx_count++;
				if (rx_count % 32 == 0)
					rx_calm = ($urandom_range(0, 9) < 3);
				rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: count cycles with work outstanding and no beat on either side
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
			    !(staged || in_valid || tick_q.size() != 0 || result_q.size() != 0))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	task automatic write_reg(input pcfc_pkg::cfg_reg_t idx, input logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pcfc_pkg::CFG_GLOBAL_THRESHOLD: gthr_set = val[7:0];
			pcfc_pkg::CFG_BASELINE_VOLTAGE: base_set = val;
			pcfc_pkg::CFG_CHARGE_GAIN:      gain_set = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [7:0] g, input logic [16:0] b, input logic [15:0] k);
		write_reg(pcfc_pkg::CFG_GLOBAL_THRESHOLD, {9'd0, g});
		write_reg(pcfc_pkg::CFG_BASELINE_VOLTAGE, b);
		write_reg(pcfc_pkg::CFG_CHARGE_GAIN, {1'b0, k});
	endtask

	task automatic add_tick(input int ch, input int chg, input bit smp, input bit crst,
	                        input bit xrst, input int trim);
		tick_t t;
		t.channel = ch[5:0];
		t.charge = chg[15:0];
		t.sample = smp;
		t.ch_rst = crst;
		t.chip_rst = xrst;
		t.trim = trim[4:0];
		t.gap = $urandom_range(0, 10);
		gen_samp[ch] = smp;
		tick_q.push_back(t);
	endtask

	// mostly a few busy channels with small charges; full-range noise now and then
	task automatic add_random_ticks(input int n, input int n_burst);
		int    hot [4];
		int    ch;
		int    r;
		bit    calm;
		tick_t t;
		@(negedge clk);
		calm = 1'b0;
		for (int i = 0; i < 4; i++)
			hot[i] = $urandom_range(0, CH_N - 1);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				calm = ($urandom_range(0, 9) < 3);
			ch = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 3)]
			                                : $urandom_range(0, CH_N - 1);
			r = $urandom_range(0, 99);
			if (r < 50)
				t.charge = 16'($urandom_range(0, 16) - 8);
			else if (r < 80)
				t.charge = 16'($urandom_range(0, 1024) - 512);
			else
				t.charge = 16'($urandom);
			if ($urandom_range(0, 2) == 0)
				gen_samp[ch] = !gen_samp[ch];
			t.channel = ch[5:0];
			t.sample = gen_samp[ch];
			t.ch_rst = ($urandom_range(0, 19) == 0);
			t.chip_rst = ($urandom_range(0, 24) == 0);
			t.trim = 5'($urandom_range(0, 31));
			t.gap = (calm || i < n_burst) ? 0 : $urandom_range(0, 10);
			tick_q.push_back(t);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (staged || in_valid || tick_q.size() != 0 || result_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_regs(8'd0, 17'd32768, 16'd256);
		@(negedge clk);

		// directed: saturation both ways, code extremes, resets, threshold edges
		add_tick(0, 0, 1, 0, 0, 0);
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(63, -32768, 1, 0, 0, 31);
		add_tick(63, 0, 0, 0, 0, 31);
		add_tick(1, 32767, 1, 0, 0, 0);
		add_tick(1, 32767, 1, 0, 0, 0);
		add_tick(1, 0, 0, 0, 0, 0);
		add_tick(2, 100, 1, 1, 0, 0);
		add_tick(2, -50, 0, 0, 1, 0);
		add_tick(3, -32768, 1, 0, 0, 0);
		add_tick(3, 0, 1, 1, 1, 0);
		add_tick(3, 0, 0, 0, 0, 0);
		add_tick(4, -4, 0, 0, 0, 31);
		add_tick(5, -5, 0, 0, 0, 31);
		add_tick(6, -332, 1, 0, 0, 16);
		add_tick(6, -1, 0, 0, 0, 16);
		add_tick(7, 127, 1, 0, 0, 1);
		add_tick(7, 0, 0, 0, 0, 2);
		add_tick(42, -21846, 1, 0, 0, 21);
		add_tick(21, 21845, 0, 1, 1, 10);
		add_tick(42, 0, 0, 1, 0, 10);
		drain();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_regs(8'd0, 17'd0, 16'd0);
				1: set_regs(8'd255, 17'd117965, 16'd65535);
				2: set_regs(8'($urandom), 17'($urandom_range(0, 117965)),
				            16'($urandom_range(1, 512)));
				3: set_regs(8'($urandom), 17'($urandom_range(0, 117965)), 16'($urandom));
				default: set_regs(8'($urandom), 17'($urandom_range(0, 117965)),
				                  16'($urandom_range(1, 32)));
			endcase
			if (p == 2) begin
				// hold off the receiver while the sender keeps pushing beats
				@(negedge clk);
				hold_seq++;
				add_random_ticks(380, 60);
			end else begin
				add_random_ticks(380, 0);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
